// File: hdl/uvs_pkg.sv
// uvs_pkg: shared constants, types and fixed-point helpers for the uv sphere tessellator
// no dependencies; imported by uvs_div, uvs_sin and uv_sphere_tessellator

package uvs_pkg;

   localparam int UVS_MAX_GRID       = 256;
   localparam int UVS_UNIT_FRAC_BITS = 14;

   localparam int CNT_W   = 9;
   localparam int IDX_W   = 8;
   localparam int RAD_W   = 16;
   localparam int CRN_W   = 16;
   localparam int PHASE_W = 32;
   localparam int NUM_W   = IDX_W + PHASE_W;
   localparam int DEN_W   = CNT_W;

   localparam int DIV_BITS   = 5;
   localparam int DIV_STAGES = NUM_W / DIV_BITS;
   localparam int SIN_LAT    = 7;
   localparam int PIPE_DEPTH = DIV_STAGES + SIN_LAT + 1;

   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [1:0] REG_RING_COUNT    = 2'd0;
   localparam logic [1:0] REG_SECTOR_COUNT  = 2'd1;
   localparam logic [1:0] REG_SPHERE_RADIUS = 2'd2;

   localparam logic [CNT_W-1:0] RING_COUNT_RST   = 9'd15;
   localparam logic [CNT_W-1:0] SECTOR_COUNT_RST = 9'd15;
   localparam logic [RAD_W-1:0] RADIUS_RST       = 16'd256;

   localparam logic               FUNC_VERTEX = 1'b0;
   localparam logic               FUNC_QUAD   = 1'b1;

   localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
   localparam logic [31:0]        QUARTER = 32'h4000_0000;
   localparam logic signed [31:0] SIN_C1  = 32'sd1686629713;
   localparam logic signed [31:0] SIN_C3  = -32'sd693598669;
   localparam logic signed [31:0] SIN_C5  = 32'sd85569306;
   localparam logic signed [31:0] SIN_C7  = -32'sd5026995;
   localparam logic signed [31:0] SIN_C9  = 32'sd172272;

   typedef struct packed {
      logic             valid;
      logic             kind;
      logic             err;
      logic [CRN_W-1:0] corner_a;
      logic [CRN_W-1:0] corner_b;
      logic [CRN_W-1:0] corner_c;
      logic [CRN_W-1:0] corner_d;
   } meta_type;

   // a*b/2^30, rounded half away from zero
   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic        neg;
      logic [31:0] ua;
      logic [31:0] ub;
      logic [63:0] p;
      logic [31:0] r;
      neg = a[31] ^ b[31];
      ua  = a[31] ? 32'(-a) : 32'(a);
      ub  = b[31] ? 32'(-b) : 32'(b);
      p   = 64'(ua) * 64'(ub) + 64'h2000_0000;
      r   = p[61:30];
      return neg ? $signed(-r) : $signed(r);
   endfunction

endpackage

// File: hdl/uvs_div.sv
// uvs_div: pipelined restoring divider, DIV_BITS (5) quotient bits per stage
// depends on uvs_pkg

module uvs_div
   import uvs_pkg::*;
(
   input  logic               clock,
   input  logic [NUM_W-1:0]   num,
   input  logic [DEN_W-1:0]   den,
   output logic [PHASE_W-1:0] quot
);

   logic [NUM_W-1:0] num_ff [DIV_STAGES];
   logic [DEN_W-1:0] rem_ff [DIV_STAGES];
   logic [DEN_W-1:0] den_ff [DIV_STAGES];
   logic [NUM_W-1:0] num_in [DIV_STAGES];
   logic [DEN_W-1:0] rem_in [DIV_STAGES];
   logic [DEN_W-1:0] den_in [DIV_STAGES];

   always_comb begin
      logic [NUM_W-1:0] n;
      logic [DEN_W-1:0] r;
      logic [DEN_W-1:0] d;
      logic [DEN_W:0]   rx;
      logic             ge;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            n = num;
            r = '0;
            d = den;
         end else begin
            n = num_ff[s-1];
            r = rem_ff[s-1];
            d = den_ff[s-1];
         end
         for (int b = 0; b < DIV_BITS; b++) begin
            rx = {r, n[NUM_W-1]};
            ge = (rx >= {1'b0, d});
            n  = {n[NUM_W-2:0], ge};
            r  = ge ? DEN_W'(rx - {1'b0, d}) : rx[DEN_W-1:0];
         end
         num_in[s] = n;
         rem_in[s] = r;
         den_in[s] = d;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         num_ff[s] <= num_in[s];
         rem_ff[s] <= rem_in[s];
         den_ff[s] <= den_in[s];
      end
   end

   assign quot = num_ff[DIV_STAGES-1][PHASE_W-1:0];

endmodule

// File: hdl/uvs_sin.sv
// uvs_sin: pipelined sine of a 32-bit phase, q30 result, quadrant fold plus odd polynomial
// depends on uvs_pkg

module uvs_sin
   import uvs_pkg::*;
(
   input  logic                     clock,
   input  logic [PHASE_W-1:0]       phase,
   output logic signed [31:0]       sine
);

   logic [1:0]         quad_ff [6];
   logic [30:0]        t_ff    [6];
   logic signed [31:0] t2_ff   [1:5];
   logic signed [31:0] acc_ff  [2:5];
   logic signed [31:0] out_ff;
   logic [30:0]        t_in;
   logic signed [31:0] fin;

   always_comb begin
      t_in = phase[30] ? 31'(31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
      fin  = mul_q30(acc_ff[5], {1'b0, t_ff[5]});
      if (fin > Q30_ONE) begin
         fin = Q30_ONE;
      end
      if (fin < 0) begin
         fin = '0;
      end
      if (quad_ff[5][1]) begin
         fin = -fin;
      end
   end

   always_ff @(posedge clock) begin
      quad_ff[0] <= phase[31:30];
      t_ff[0]    <= t_in;
      for (int s = 1; s < 6; s++) begin
         quad_ff[s] <= quad_ff[s-1];
         t_ff[s]    <= t_ff[s-1];
      end
      t2_ff[1] <= mul_q30({1'b0, t_ff[0]}, {1'b0, t_ff[0]});
      for (int s = 2; s < 6; s++) begin
         t2_ff[s] <= t2_ff[s-1];
      end
      acc_ff[2] <= SIN_C7 + mul_q30(SIN_C9, t2_ff[1]);
      acc_ff[3] <= SIN_C5 + mul_q30(acc_ff[2], t2_ff[2]);
      acc_ff[4] <= SIN_C3 + mul_q30(acc_ff[3], t2_ff[3]);
      acc_ff[5] <= SIN_C1 + mul_q30(acc_ff[4], t2_ff[4]);
      out_ff    <= fin;
   end

   assign sine = out_ff;

endmodule

// File: hdl/uv_sphere_tessellator.sv
// uv_sphere_tessellator: top level, vertex position/normal and quad index generator
// depends on uvs_pkg, uvs_div, uvs_sin
//
//   channel   ports                         direction  handshake
//   request   req_func/ring/sector          in         start high, busy low
//   result    rsp_kind ... rsp_corner_d     out        rsp_valid, one cycle
//   config    psel/penable/pwrite/paddr..   in/out     apb read/write, pready tied high
//
// one item per cycle; rsp_valid follows the accepting edge through the entry register,
// the 8-stage phase divider, the 7-stage sine pipeline and two more registers
// busy is never raised, the pipeline has no hold points and results cannot be stalled
// reset is synchronous and clears the valid chain, rsp_valid and the config registers

module uv_sphere_tessellator
   import uvs_pkg::*;
#(
   parameter int MAX_GRID       = UVS_MAX_GRID,
   parameter int UNIT_FRAC_BITS = UVS_UNIT_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_func,
   input  logic [IDX_W-1:0]        req_ring,
   input  logic [IDX_W-1:0]        req_sector,
   output logic                    rsp_valid,
   output logic                    rsp_kind,
   output logic                    rsp_error,
   output logic signed [16:0]      rsp_pos_x,
   output logic signed [17:0]      rsp_pos_y,
   output logic signed [16:0]      rsp_pos_z,
   output logic signed [15:0]      rsp_norm_x,
   output logic signed [15:0]      rsp_norm_y,
   output logic signed [15:0]      rsp_norm_z,
   output logic [CRN_W-1:0]        rsp_corner_a,
   output logic [CRN_W-1:0]        rsp_corner_b,
   output logic [CRN_W-1:0]        rsp_corner_c,
   output logic [CRN_W-1:0]        rsp_corner_d,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   localparam int          UNIT_SH  = 30 - UNIT_FRAC_BITS;
   localparam logic [31:0] UNIT_RND = (UNIT_SH > 0) ? (32'd1 << (UNIT_SH - 1)) : 32'd0;
   localparam logic [10:0] GRID_MAX = 11'(MAX_GRID);

   logic [CNT_W-1:0] ring_count_ff;
   logic [CNT_W-1:0] sector_count_ff;
   logic [RAD_W-1:0] radius_ff;

   meta_type         meta_ff [PIPE_DEPTH+1];
   meta_type         meta_in;
   logic [NUM_W-1:0] num_t_ff, num_p_ff, num_t_in, num_p_in;
   logic [DEN_W-1:0] dr_ff, ds_ff, dr_in, ds_in;

   logic [PHASE_W-1:0] q_t, q_p;
   logic signed [31:0] sin_t, cos_t, sin_p, cos_p;
   logic signed [31:0] nx_ff, ny_ff, nz_ff;

   logic             accept;
   logic             cfg_wr;
   logic [CNT_W-1:0] rings, sectors;

   logic signed [31:0] rad_s, px, py, pz;
   logic signed [15:0] ux, uy, uz;
   logic               vert_ok;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
      if (c < CNT_W'(2)) begin
         return CNT_W'(2);
      end else if ({2'b00, c} > GRID_MAX) begin
         return GRID_MAX[CNT_W-1:0];
      end
      return c;
   endfunction

   function automatic logic signed [15:0] to_unit(input logic signed [31:0] v);
      logic [31:0] u;
      u = v[31] ? 32'(-v) : 32'(v);
      u = (u + UNIT_RND) >> UNIT_SH;
      return v[31] ? 16'(-u) : u[15:0];
   endfunction

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start & ~busy;
   assign cfg_wr = psel & penable & pwrite & pready;

   always_comb begin
      case (paddr[3:2])
         REG_RING_COUNT:    prdata = DATA_W'(ring_count_ff);
         REG_SECTOR_COUNT:  prdata = DATA_W'(sector_count_ff);
         REG_SPHERE_RADIUS: prdata = DATA_W'(radius_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff   <= RING_COUNT_RST;
         sector_count_ff <= SECTOR_COUNT_RST;
         radius_ff       <= RADIUS_RST;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_RING_COUNT:    ring_count_ff   <= pwdata[CNT_W-1:0];
            REG_SECTOR_COUNT:  sector_count_ff <= pwdata[CNT_W-1:0];
            REG_SPHERE_RADIUS: radius_ff       <= pwdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // entry stage: range check, quad indices, phase numerators
   always_comb begin
      logic [17:0] base;
      logic [17:0] next;
      rings   = clamp_count(ring_count_ff);
      sectors = clamp_count(sector_count_ff);
      dr_in   = CNT_W'(rings - CNT_W'(1));
      ds_in   = CNT_W'(sectors - CNT_W'(1));
      base    = 18'(req_ring) * 18'(sectors) + 18'(req_sector);
      next    = base + 18'(sectors);
      meta_in = '0;
      meta_in.valid = accept;
      meta_in.kind  = req_func;
      if (req_func == FUNC_VERTEX) begin
         meta_in.err = ({1'b0, req_ring} >= rings) || ({1'b0, req_sector} >= sectors);
      end else begin
         meta_in.err = ({1'b0, req_ring} >= dr_in) || ({1'b0, req_sector} >= ds_in);
         if (!meta_in.err) begin
            meta_in.corner_a = base[CRN_W-1:0];
            meta_in.corner_b = CRN_W'(base + 18'd1);
            meta_in.corner_c = CRN_W'(next + 18'd1);
            meta_in.corner_d = next[CRN_W-1:0];
         end
      end
      num_t_in = {1'b0, req_ring, 31'd0} + NUM_W'(dr_in[CNT_W-1:1]);
      num_p_in = {req_sector, 32'd0} + NUM_W'(ds_in[CNT_W-1:1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= PIPE_DEPTH; s++) begin
            meta_ff[s].valid <= 1'b0;
         end
      end else begin
         meta_ff[0].valid <= meta_in.valid;
         for (int s = 1; s <= PIPE_DEPTH; s++) begin
            meta_ff[s].valid <= meta_ff[s-1].valid;
         end
      end
      meta_ff[0].kind     <= meta_in.kind;
      meta_ff[0].err      <= meta_in.err;
      meta_ff[0].corner_a <= meta_in.corner_a;
      meta_ff[0].corner_b <= meta_in.corner_b;
      meta_ff[0].corner_c <= meta_in.corner_c;
      meta_ff[0].corner_d <= meta_in.corner_d;
      for (int s = 1; s <= PIPE_DEPTH; s++) begin
         meta_ff[s].kind     <= meta_ff[s-1].kind;
         meta_ff[s].err      <= meta_ff[s-1].err;
         meta_ff[s].corner_a <= meta_ff[s-1].corner_a;
         meta_ff[s].corner_b <= meta_ff[s-1].corner_b;
         meta_ff[s].corner_c <= meta_ff[s-1].corner_c;
         meta_ff[s].corner_d <= meta_ff[s-1].corner_d;
      end
      num_t_ff <= num_t_in;
      num_p_ff <= num_p_in;
      dr_ff    <= dr_in;
      ds_ff    <= ds_in;
   end

   uvs_div u_div_theta (.clock(clock), .num(num_t_ff), .den(dr_ff), .quot(q_t));
   uvs_div u_div_phi   (.clock(clock), .num(num_p_ff), .den(ds_ff), .quot(q_p));

   uvs_sin u_sin_t (.clock(clock), .phase(q_t),                  .sine(sin_t));
   uvs_sin u_cos_t (.clock(clock), .phase(PHASE_W'(q_t + QUARTER)), .sine(cos_t));
   uvs_sin u_sin_p (.clock(clock), .phase(q_p),                  .sine(sin_p));
   uvs_sin u_cos_p (.clock(clock), .phase(PHASE_W'(q_p + QUARTER)), .sine(cos_p));

   always_ff @(posedge clock) begin
      nx_ff <= mul_q30(cos_p, sin_t);
      ny_ff <= -cos_t;
      nz_ff <= mul_q30(sin_p, sin_t);
   end

   always_comb begin
      rad_s   = $signed({16'd0, radius_ff});
      px      = mul_q30(rad_s, nx_ff);
      py      = mul_q30(rad_s, ny_ff) + rad_s;
      pz      = mul_q30(rad_s, nz_ff);
      ux      = to_unit(nx_ff);
      uy      = to_unit(ny_ff);
      uz      = to_unit(nz_ff);
      vert_ok = (meta_ff[PIPE_DEPTH].kind == FUNC_VERTEX) && !meta_ff[PIPE_DEPTH].err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= meta_ff[PIPE_DEPTH].valid;
      end
      rsp_kind     <= meta_ff[PIPE_DEPTH].kind;
      rsp_error    <= meta_ff[PIPE_DEPTH].err;
      rsp_corner_a <= meta_ff[PIPE_DEPTH].corner_a;
      rsp_corner_b <= meta_ff[PIPE_DEPTH].corner_b;
      rsp_corner_c <= meta_ff[PIPE_DEPTH].corner_c;
      rsp_corner_d <= meta_ff[PIPE_DEPTH].corner_d;
      rsp_pos_x    <= vert_ok ? px[16:0] : '0;
      rsp_pos_y    <= vert_ok ? py[17:0] : '0;
      rsp_pos_z    <= vert_ok ? pz[16:0] : '0;
      rsp_norm_x   <= vert_ok ? ux : '0;
      rsp_norm_y   <= vert_ok ? uy : '0;
      rsp_norm_z   <= vert_ok ? uz : '0;
   end

endmodule
